>>> src/pat_pkg.sv
// peer address table: shared constants, codes and controller/datapath link types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

    localparam int NUM_PEERS  = 8;
    localparam int NUM_IFACES = 2;
    localparam int MAC_W      = 48;
    localparam int SLOT_W     = 4;
    localparam int IFACE_W    = 1;
    localparam int PEER_IDX_W = $clog2(NUM_PEERS);
    localparam int NUM_SLOTS  = NUM_PEERS + 1;

    localparam logic [SLOT_W-1:0] GROUP_SLOT = SLOT_W'(NUM_PEERS);

    // multicast bit: low bit of the first octet
    localparam int MCAST_BIT = 40;

    // register map
    localparam int  PADDR_W      = 3;
    localparam logic REG_AP_MASK = 1'b0;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic load;        // capture input word
        logic exec_emit;   // run the operation, write its first result
        logic scan_step;   // advance flush scan pointer
        logic flush_emit;  // clear scanned slot and write its result
    } pat_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic op_flush;    // captured operation is a flush
        logic any_match;   // some peer slot belongs to the flushed interface
        logic cur_match;   // scanned slot belongs to the flushed interface
        logic more_after;  // a later peer slot belongs to it too
    } pat_stat_t;

endpackage

`default_nettype wire

>>> src/pat_ctrl.sv
// peer address table controller: sequences capture, execute and flush scan
// depends on pat_pkg
`timescale 1ns / 1ps
`default_nettype none

module pat_ctrl
    import pat_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire pat_stat_t stat,
    output pat_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_stall       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec_emit = 1'b1;
                    if (stat.op_flush && stat.any_match)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                // skip slots of other interfaces, wait on output for matches
                cmd.scan_step  = !stat.cur_match || stat.out_free;
                cmd.flush_emit = stat.cur_match && stat.out_free;
                if (cmd.flush_emit && !stat.more_after)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> src/pat_dp.sv
// peer address table datapath: slot store, compare and priority logic, result register
// depends on pat_pkg
`timescale 1ns / 1ps
`default_nettype none

module pat_dp
    import pat_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pat_cmd_t              cmd,
    output pat_stat_t                  stat,
    input  wire logic [NUM_IFACES-1:0] ap_mask,
    input  wire logic [1:0]            op,
    input  wire logic [MAC_W-1:0]      peer_mac,
    input  wire logic [IFACE_W-1:0]    iface,
    input  wire logic                  legacy_flag,
    input  wire logic                  qos_flag,
    input  wire logic [SLOT_W-1:0]     slot_index,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 status,
    output logic [SLOT_W-1:0]          slot,
    output logic                       notify,
    output logic [MAC_W-1:0]           notify_mac,
    output logic                       last
);

    // captured word
    op_t                 op_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [IFACE_W-1:0]  iface_reg;
    logic                legacy_reg;
    logic                qos_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [PEER_IDX_W-1:0] scan_reg;

    // slot store
    logic                used_reg   [NUM_SLOTS];
    logic [IFACE_W-1:0]  iface_tbl_reg [NUM_SLOTS];
    logic [MAC_W-1:0]    mac_tbl_reg   [NUM_SLOTS];
    logic                legacy_tbl_reg [NUM_SLOTS];
    logic                qos_tbl_reg    [NUM_SLOTS];

    // result register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_notify_reg;
    logic [MAC_W-1:0]    out_mac_reg;
    logic                out_last_reg;

    logic                  mcast;
    logic                  ap;
    logic                  hit_any;
    logic [PEER_IDX_W-1:0] hit_idx;
    logic                  free_any;
    logic [PEER_IDX_W-1:0] free_idx;
    logic [NUM_PEERS-1:0]  fmatch;
    logic                  more_after;

    // result and store write for the current command
    status_t             res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic                res_notify;
    logic [MAC_W-1:0]    res_mac;
    logic                res_last;
    logic                wr_en;
    logic                wr_data_en;
    logic [SLOT_W-1:0]   wr_sel;
    logic                wr_used;
    logic [IFACE_W-1:0]  wr_iface;
    logic                wr_legacy;
    logic [MAC_W-1:0]    wr_mac;
    logic                wr_qos;
    logic                grp_free;
    logic                out_load;

    assign mcast = mac_reg[MCAST_BIT];
    assign ap    = ap_mask[iface_reg];

    // lowest used slot holding the address, lowest free slot
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = NUM_PEERS - 1; s >= 0; s--)
        begin
            if (used_reg[s] && (mac_tbl_reg[s] == mac_reg))
            begin
                hit_any = 1'b1;
                hit_idx = PEER_IDX_W'(s);
            end
            if (!used_reg[s])
            begin
                free_any = 1'b1;
                free_idx = PEER_IDX_W'(s);
            end
        end
    end

    always_comb
    begin
        more_after = 1'b0;
        for (int s = 0; s < NUM_PEERS; s++)
        begin
            fmatch[s] = (iface_tbl_reg[s] == iface_reg);
            if ((PEER_IDX_W'(s) > scan_reg) && fmatch[s])
            begin
                more_after = 1'b1;
            end
        end
    end

    assign out_load = cmd.exec_emit || cmd.flush_emit;

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.op_flush   = (op_reg == OP_FLUSH);
    assign stat.any_match  = |fmatch;
    assign stat.cur_match  = fmatch[scan_reg];
    assign stat.more_after = more_after;

    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_notify = 1'b0;
        res_mac    = '0;
        res_last   = 1'b1;
        wr_en      = 1'b0;
        wr_data_en = 1'b0;
        wr_sel     = '0;
        wr_used    = 1'b0;
        wr_iface   = '0;
        wr_legacy  = 1'b0;
        wr_mac     = '0;
        wr_qos     = 1'b0;
        grp_free   = 1'b0;
        if (cmd.flush_emit)
        begin
            res_slot   = SLOT_W'(scan_reg);
            res_notify = ap;
            res_last   = !more_after;
            wr_en      = 1'b1;
            wr_data_en = 1'b1;
            wr_sel     = SLOT_W'(scan_reg);
        end
        else if (cmd.exec_emit)
        begin
            case (op_reg)
                OP_LOOKUP:
                begin
                    if (mcast)
                    begin
                        res_slot = GROUP_SLOT;
                    end
                    else if (hit_any)
                    begin
                        res_slot = SLOT_W'(hit_idx);
                    end
                    else
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                OP_ADD:
                begin
                    if (mcast && ap)
                    begin
                        // group claim keeps the stored address and qos bit
                        res_slot  = GROUP_SLOT;
                        wr_en     = 1'b1;
                        wr_sel    = GROUP_SLOT;
                        wr_used   = 1'b1;
                        wr_iface  = iface_reg;
                        wr_legacy = 1'b1;
                    end
                    else if (free_any)
                    begin
                        res_slot   = SLOT_W'(free_idx);
                        res_notify = ap;
                        res_mac    = ap ? mac_reg : '0;
                        wr_en      = 1'b1;
                        wr_data_en = 1'b1;
                        wr_sel     = SLOT_W'(free_idx);
                        wr_used    = 1'b1;
                        wr_iface   = iface_reg;
                        wr_legacy  = legacy_reg;
                        wr_mac     = mac_reg;
                        wr_qos     = qos_reg;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                OP_REMOVE:
                begin
                    res_slot = idx_reg;
                    if (idx_reg > GROUP_SLOT)
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        res_notify = ap;
                        wr_en      = 1'b1;
                        wr_data_en = 1'b1;
                        wr_sel     = idx_reg;
                    end
                end
                OP_FLUSH:
                begin
                    res_slot = GROUP_SLOT;
                    res_last = !(|fmatch);
                    grp_free = 1'b1;
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // control state: valid flags, interface tags, scan pointer, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                used_reg[s]      <= 1'b0;
                iface_tbl_reg[s] <= '0;
            end
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                used_reg[wr_sel]      <= wr_used;
                iface_tbl_reg[wr_sel] <= wr_iface;
            end
            if (grp_free)
            begin
                used_reg[NUM_PEERS] <= 1'b0;
            end
            if (cmd.load)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: captured word, stored attributes, result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(op);
            mac_reg    <= peer_mac;
            iface_reg  <= iface;
            legacy_reg <= legacy_flag;
            qos_reg    <= qos_flag;
            idx_reg    <= slot_index;
        end
        if (wr_en)
        begin
            legacy_tbl_reg[wr_sel] <= wr_legacy;
        end
        if (wr_data_en)
        begin
            mac_tbl_reg[wr_sel] <= wr_mac;
            qos_tbl_reg[wr_sel] <= wr_qos;
        end
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_notify_reg <= res_notify;
            out_mac_reg    <= res_mac;
            out_last_reg   <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign notify     = out_notify_reg;
    assign notify_mac = out_mac_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

>>> src/peer_address_table_unit.sv
// an accepted input word is captured, then its first result is written into the
// result register once that register is free; lookup, add and remove are captured,
//   then executed; a flush then scans the peer slots one slot per cycle, waiting on
//   the output at matching slots, and stops after the last one; input stalls till done
// reset (rst_n low, async): every slot free with interface 0, access-point mask 0
// top level of the peer address table; depends on pat_pkg, pat_ctrl, pat_dp
`timescale 1ns / 1ps
`default_nettype none

module peer_address_table_unit
    import pat_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [MAC_W-1:0]   peer_mac,
    input  wire logic [IFACE_W-1:0] iface,
    input  wire logic               legacy_flag,
    input  wire logic               qos_flag,
    input  wire logic [SLOT_W-1:0]  slot_index,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [SLOT_W-1:0]       slot,
    output logic                    notify,
    output logic [MAC_W-1:0]        notify_mac,
    output logic                    last
);

    // access-point mask register, one bit per interface
    logic [NUM_IFACES-1:0] ap_mask_reg;
    logic [NUM_IFACES-1:0] ap_mask_next;
    logic                  cfg_wr;

    pat_cmd_t  cmd;
    pat_stat_t stat;

    // writes land in the access cycle; only word address 0 holds a register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AP_MASK);

    assign ap_mask_next = cfg_wr ? pwdata[NUM_IFACES-1:0] : ap_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ap_mask_reg <= '0;
        end
        else
        begin
            ap_mask_reg <= ap_mask_next;
        end
    end

    // reads of unmapped addresses return zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_AP_MASK)
        begin
            prdata[NUM_IFACES-1:0] = ap_mask_reg;
        end
    end

    // controller: idle -> execute -> (flush scan) -> idle
    pat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: slot store with parallel address compare and first-free pick,
    // flush scan pointer, and the result register that decouples out_stall
    pat_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .ap_mask     (ap_mask_reg),
        .op          (op),
        .peer_mac    (peer_mac),
        .iface       (iface),
        .legacy_flag (legacy_flag),
        .qos_flag    (qos_flag),
        .slot_index  (slot_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .notify      (notify),
        .notify_mac  (notify_mac),
        .last        (last)
    );

endmodule

`default_nettype wire
